### sv/srtfl_pkg.sv
// shared types and constants for the sorted rate table floor lookup
package srtfl_pkg;

	// field widths
	localparam int KEY_W      = 16;
	localparam int VAL_W      = 48;
	localparam int EXV_W      = 58;
	localparam int ST_W       = 3;
	localparam int FRAC_W     = 16;

	// stream packing
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 80;

	// multiplier datapath: rate times one 16-bit slice of the amount
	localparam int CHUNK_W = 16;
	localparam int PROD_W  = VAL_W + CHUNK_W + 1;
	localparam int ACC_W   = EXV_W + FRAC_W;

	// largest accepted amount, 1000.0 in q16
	localparam int AMOUNT_MAX_INT = 1000;
	localparam logic signed [VAL_W-1:0] AMOUNT_LIMIT =
		VAL_W'(AMOUNT_MAX_INT * (2 ** FRAC_W));

	// item kinds
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef enum logic [ST_W-1:0] {
		STAT_OK,
		STAT_DUP,
		STAT_FULL,
		STAT_NEG,
		STAT_BIG,
		STAT_NORATE
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_INS_WR,
		S_MUL_LO,
		S_MUL_HI,
		S_MUL_ACC,
		S_RESP
	} state_t;

endpackage

### sv/sorted_rate_table_floor_lookup.sv
// sorted key/rate table with binary-search floor lookup and q16 product
//
// channel | dir | tdata (low bit up)                      | tuser
// s_*     | in  | date_key[15:0], value_fixed[63:16]      | action[0]
// m_*     | out | exchange_value[57:0], matched_date[73:58], zero pad | status[2:0]
//
// a query binary-searches the n stored entries, each probe a read and a compare
// state on the registered-read key/rate memories, then runs the split 48x16
// multiply in low, high and accumulate steps; an amount refused by range skips
// the search. an insert searches the same way, then the entries above
// the new key are moved up one at a time through the same memory port.
// after reset the entry count is zero; memory contents are never cleared.
// the output register lets the next item be taken while a result waits.
module sorted_rate_table_floor_lookup #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// date_key[15:0], value_fixed[63:16]
	input  logic [srtfl_pkg::IN_TDATA_W-1:0]    s_tdata,
	// action[0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// exchange_value[57:0], matched_date[73:58], zero fill above
	output logic [srtfl_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// status[2:0]
	output logic [srtfl_pkg::ST_W-1:0]          m_tuser
);
	import srtfl_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t state_q, state_d;

	// item registers
	logic                    act_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] val_q;

	// search registers
	logic [CW-1:0]           lo_q, hi_q, mid_q, idx_q, entry_count_q;
	logic [CW-1:0]           mid;
	logic                    found_q;
	logic [KEY_W-1:0]        found_key_q;
	logic signed [VAL_W-1:0] found_rate_q;

	// memories and their ports
	logic [KEY_W-1:0]        keys_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]        rates_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]        rd_key_q;
	logic [VAL_W-1:0]        rd_rate_q;
	logic [CW-1:0]           raddr, waddr;
	logic                    mem_we;
	logic [KEY_W-1:0]        wkey;
	logic [VAL_W-1:0]        wrate;

	// multiplier
	logic [CHUNK_W-1:0]       mul_chunk;
	logic signed [PROD_W-1:0] mul_res, prod_q;
	logic signed [ACC_W-1:0]  prod_ext, acc_q, acc_sum;

	// result and output registers
	status_t                 res_status_q;
	logic [EXV_W-1:0]        res_value_q;
	logic [KEY_W-1:0]        res_date_q;
	logic                    m_tvalid_q;
	status_t                 m_status_q;
	logic [EXV_W-1:0]        m_value_q;
	logic [KEY_W-1:0]        m_date_q;

	logic                    in_xfer, out_load;
	logic signed [VAL_W-1:0] in_val;

	assign in_val   = $signed(s_tdata[KEY_W +: VAL_W]);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == S_RESP) && (!m_tvalid_q || m_tready);
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);

	// shared multiplier over the low and high amount slices
	assign mul_chunk = (state_q == S_MUL_LO) ? val_q[CHUNK_W-1:0]
	                                         : val_q[2*CHUNK_W-1:CHUNK_W];
	assign mul_res   = $signed(found_rate_q) * $signed({1'b0, mul_chunk});
	assign prod_ext  = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign acc_sum   = acc_q + {prod_ext[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};

	// next state and memory port control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		raddr    = mid;
		waddr    = idx_q;
		mem_we   = 1'b0;
		wkey     = rd_key_q;
		wrate    = rd_rate_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == ACT_QUERY &&
					    (in_val < 0 || in_val > AMOUNT_LIMIT)) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SRCH_RD;
					end
				end
			end
			S_SRCH_RD: begin
				state_d = (lo_q < hi_q) ? S_SRCH_CMP : S_DECIDE;
			end
			S_SRCH_CMP: begin
				state_d = S_SRCH_RD;
			end
			S_DECIDE: begin
				if (act_q == ACT_INSERT) begin
					if ((found_q && found_key_q == key_q) ||
					    entry_count_q >= CW'(TABLE_DEPTH)) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SHIFT_RD;
					end
				end else begin
					state_d = found_q ? S_MUL_LO : S_RESP;
				end
			end
			S_SHIFT_RD: begin
				raddr   = idx_q - CW'(1);
				state_d = (idx_q > lo_q) ? S_SHIFT_WR : S_INS_WR;
			end
			S_SHIFT_WR: begin
				mem_we  = 1'b1;
				state_d = S_SHIFT_RD;
			end
			S_INS_WR: begin
				mem_we  = 1'b1;
				waddr   = lo_q;
				wkey    = key_q;
				wrate   = val_q;
				state_d = S_RESP;
			end
			S_MUL_LO:  state_d = S_MUL_HI;
			S_MUL_HI:  state_d = S_MUL_ACC;
			S_MUL_ACC: state_d = S_RESP;
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// key and rate memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			keys_mem[waddr[AW-1:0]]  <= wkey;
			rates_mem[waddr[AW-1:0]] <= wrate;
		end
		rd_key_q  <= keys_mem[raddr[AW-1:0]];
		rd_rate_q <= rates_mem[raddr[AW-1:0]];
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (state_q == S_INS_WR) begin
			entry_count_q <= entry_count_q + CW'(1);
		end
	end

	// search, shift and multiply datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					act_q        <= s_tuser;
					key_q        <= s_tdata[KEY_W-1:0];
					val_q        <= in_val;
					lo_q         <= '0;
					hi_q         <= entry_count_q;
					found_q      <= 1'b0;
					res_value_q  <= '0;
					res_date_q   <= '0;
					res_status_q <= STAT_OK;
					if (s_tuser == ACT_QUERY && in_val < 0) begin
						res_status_q <= STAT_NEG;
					end else if (s_tuser == ACT_QUERY && in_val > AMOUNT_LIMIT) begin
						res_status_q <= STAT_BIG;
					end
				end
			end
			S_SRCH_RD: begin
				mid_q <= mid;
			end
			S_SRCH_CMP: begin
				// keep the last probe at or below the key: that is the floor entry
				if (rd_key_q <= key_q) begin
					lo_q         <= mid_q + CW'(1);
					found_q      <= 1'b1;
					found_key_q  <= rd_key_q;
					found_rate_q <= $signed(rd_rate_q);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_DECIDE: begin
				idx_q <= entry_count_q;
				if (act_q == ACT_INSERT) begin
					if (found_q && found_key_q == key_q) begin
						res_status_q <= STAT_DUP;
					end else if (entry_count_q >= CW'(TABLE_DEPTH)) begin
						res_status_q <= STAT_FULL;
					end
				end else if (!found_q) begin
					res_status_q <= STAT_NORATE;
				end
			end
			S_SHIFT_WR: begin
				idx_q <= idx_q - CW'(1);
			end
			S_MUL_LO: begin
				prod_q <= mul_res;
			end
			S_MUL_HI: begin
				acc_q  <= prod_ext;
				prod_q <= mul_res;
			end
			S_MUL_ACC: begin
				res_value_q <= acc_sum[ACC_W-1:FRAC_W];
				res_date_q  <= found_key_q;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q <= res_status_q;
			m_value_q  <= res_value_q;
			m_date_q   <= res_date_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{(OUT_TDATA_W-EXV_W-KEY_W){1'b0}}, m_date_q, m_value_q};

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH_RD || state_q == S_SRCH_CMP) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |=> (entry_count_q == $past(entry_count_q) + CW'(1)))
		else $error("insert did not bump entry count");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (waddr < CW'(TABLE_DEPTH) && waddr <= entry_count_q))
		else $error("memory write outside filled range");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
		else $error("refused item carries nonzero data");

endmodule

### sim/sorted_rate_table_floor_lookup_test.sv
`timescale 1ns / 100ps
// self-checking stream testbench for the sorted rate table floor lookup
module sorted_rate_table_floor_lookup_test;
	import srtfl_pkg::*;

	localparam int RATE_SLOTS = 1024;
	localparam int FILL_BASE  = 50000;	// fresh random insert keys stay below this key
	localparam int SETTLE_CYC = 200;

	typedef struct packed {
		logic                    action;
		logic [KEY_W-1:0]        date_key;
		logic signed [VAL_W-1:0] value_fixed;
	} rate_item_t;

	typedef struct packed {
		status_t                 status;
		logic signed [EXV_W-1:0] exchange_value;
		logic [KEY_W-1:0]        matched_date;
	} exchange_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [ST_W-1:0]        m_tuser;

	// items waiting to go out and results still owed by the block
	rate_item_t pending_items[$];
	exchange_t  exchange_due[$];
	rate_item_t offered;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	int         fail_count = 0;

	// stimulus-side view of which keys the table will hold
	bit key_taken [0:65535];
	int gen_keys[$];
	int gen_count = 0;

	// predicted table contents, kept in ascending date order
	logic [KEY_W-1:0]        stored_dates [RATE_SLOTS];
	logic signed [VAL_W-1:0] stored_rates [RATE_SLOTS];
	int                      stored_count = 0;

	sorted_rate_table_floor_lookup #(
		.TABLE_DEPTH(RATE_SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// number of stored dates at or below the key
	function automatic int dates_not_above(input logic [KEY_W-1:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = stored_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored_dates[mid] <= key) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	// apply one accepted item to the predicted table and queue its result
	task automatic predict_exchange(input rate_item_t item);
		exchange_t          res;
		int                 pos;
		logic signed [95:0] wide_rate;
		logic signed [95:0] wide_amount;
		logic signed [95:0] wide_prod;
		res.status = STAT_OK;
		res.exchange_value = '0;
		res.matched_date = '0;
		pos = dates_not_above(item.date_key);
		if (item.action == ACT_INSERT) begin
			if (pos > 0 && stored_dates[pos-1] == item.date_key) begin
				res.status = STAT_DUP;
			end else if (stored_count >= RATE_SLOTS) begin
				res.status = STAT_FULL;
			end else begin
				// open a slot at pos and drop the new entry in
				for (int i = stored_count; i > pos; i--) begin
					stored_dates[i] = stored_dates[i-1];
					stored_rates[i] = stored_rates[i-1];
				end
				stored_dates[pos] = item.date_key;
				stored_rates[pos] = item.value_fixed;
				stored_count++;
			end
		end else if (item.value_fixed[VAL_W-1]) begin
			res.status = STAT_NEG;
		end else if (item.value_fixed > AMOUNT_LIMIT) begin
			res.status = STAT_BIG;
		end else if (pos == 0) begin
			res.status = STAT_NORATE;
		end else begin
			// full product, then floor to q16
			wide_rate = stored_rates[pos-1];
			wide_amount = item.value_fixed;
			wide_prod = (wide_rate * wide_amount) >>> FRAC_W;
			res.exchange_value = wide_prod[EXV_W-1:0];
			res.matched_date = stored_dates[pos-1];
		end
		exchange_due.push_back(res);
	endtask

	task automatic queue_item(input logic action, input int key, input logic [VAL_W-1:0] value);
		rate_item_t item;
		item.action = action;
		item.date_key = KEY_W'(key);
		item.value_fixed = value;
		if (action == ACT_INSERT && !key_taken[key] && gen_count < RATE_SLOTS) begin
			key_taken[key] = 1'b1;
			gen_keys.push_back(key);
			gen_count++;
		end
		pending_items.push_back(item);
	endtask

	function automatic logic [VAL_W-1:0] random_word();
		logic [63:0] raw;
		raw = {$urandom(), $urandom()};
		return raw[VAL_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] pick_rate();
		int near_zero;
		near_zero = int'($urandom_range(0, 1310720)) - 655360;
		case ($urandom_range(0, 9))
			0: return {1'b0, {(VAL_W-1){1'b1}}};
			1: return {1'b1, {(VAL_W-1){1'b0}}};
			2, 3: return VAL_W'(near_zero);
			default: return random_word();
		endcase
	endfunction

	// mostly legal amounts, with negative and oversized ones mixed in
	function automatic logic [VAL_W-1:0] pick_amount();
		logic [VAL_W-1:0] raw;
		raw = random_word();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return AMOUNT_LIMIT;
			2: return AMOUNT_LIMIT + 1;
			3, 4: return {1'b1, raw[VAL_W-2:0]};
			5, 6: return {2'b01, raw[VAL_W-3:0]};
			7: return AMOUNT_LIMIT + 1 + raw[15:0];
			8: return VAL_W'(raw[15:0]);
			default: return VAL_W'($urandom_range(0, 65536000));
		endcase
	endfunction

	// query keys cluster on and just above stored dates
	function automatic int pick_query_key();
		int base;
		if (gen_keys.size() == 0 || $urandom_range(0, 3) == 0) begin
			return $urandom_range(0, 65535);
		end
		base = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
		if ($urandom_range(0, 1) == 0) begin
			return base;
		end
		base = base + $urandom_range(1, 400);
		return (base > 65535) ? 65535 : base;
	endfunction

	task automatic queue_random_items(input int n);
		int key;
		repeat (n) begin
			if ($urandom_range(0, 9) < 4) begin
				if (gen_keys.size() > 0 && $urandom_range(0, 3) == 0) begin
					key = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
				end else begin
					key = $urandom_range(0, FILL_BASE - 1);
				end
				queue_item(ACT_INSERT, key, pick_rate());
			end else begin
				queue_item(ACT_QUERY, pick_query_key(), pick_amount());
			end
		end
	endtask

	task automatic wait_results_in();
		do @(negedge clk);
		while (pending_items.size() != 0 || s_tvalid || exchange_due.size() != 0);
	endtask

	// input side: predict on each transfer, then offer the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_exchange(offered);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					offered = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {offered.value_fixed, offered.date_key};
					s_tuser <= offered.action;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side: check each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		exchange_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (exchange_due.size() == 0) begin
					$display("%0t: unexpected result: status %0d value %h date %0d", $time,
						m_tuser, m_tdata[EXV_W-1:0], m_tdata[EXV_W+KEY_W-1:EXV_W]);
					fail_count++;
				end else begin
					want = exchange_due.pop_front();
					if (m_tuser !== want.status ||
					    m_tdata[EXV_W-1:0] !== want.exchange_value ||
					    m_tdata[EXV_W+KEY_W-1:EXV_W] !== want.matched_date) begin
						$display("%0t: expected status %0d value %h date %0d, got status %0d value %h date %0d",
							$time, want.status, want.exchange_value, want.matched_date,
							m_tuser, m_tdata[EXV_W-1:0], m_tdata[EXV_W+KEY_W-1:EXV_W]);
						fail_count++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 10;
		recv_idle_pct = 48;
		// empty table, and amount range checks ahead of the search
		queue_item(ACT_QUERY, 0, 48'h10000);
		queue_item(ACT_QUERY, 65535, AMOUNT_LIMIT);
		queue_item(ACT_QUERY, 500, {VAL_W{1'b1}});
		queue_item(ACT_QUERY, 500, {1'b1, {(VAL_W-1){1'b0}}});
		queue_item(ACT_QUERY, 500, AMOUNT_LIMIT + 1);
		queue_item(ACT_QUERY, 500, {1'b0, {(VAL_W-1){1'b1}}});
		// key below the smallest stored date
		queue_item(ACT_INSERT, 100, 48'h28000);
		queue_item(ACT_QUERY, 99, 48'h10000);
		// extreme keys and rates, then a duplicate
		queue_item(ACT_INSERT, 0, {1'b0, {(VAL_W-1){1'b1}}});
		queue_item(ACT_INSERT, 65535, {1'b1, {(VAL_W-1){1'b0}}});
		queue_item(ACT_INSERT, 100, 48'h10000);
		queue_item(ACT_QUERY, 100, AMOUNT_LIMIT);
		queue_item(ACT_QUERY, 99, '0);
		queue_item(ACT_QUERY, 0, AMOUNT_LIMIT);
		queue_item(ACT_QUERY, 65535, AMOUNT_LIMIT);
		queue_item(ACT_QUERY, 65534, 48'h1);
		// negative rate: truncation rounds toward minus infinity
		queue_item(ACT_INSERT, 50, {VAL_W{1'b1}});
		queue_item(ACT_QUERY, 60, 48'h1);
		queue_item(ACT_QUERY, 60, 48'h18000);
		queue_item(ACT_INSERT, 200, '0);
		queue_item(ACT_QUERY, 300, 48'h12345);
		queue_item(ACT_QUERY, 50, AMOUNT_LIMIT + 1);
		queue_item(ACT_QUERY, 49, 48'h30000);
		queue_random_items(300);

		// sender holds off until every result is back
		wait_results_in();
		send_idle_pct = 48;
		recv_idle_pct = 10;
		queue_random_items(300);

		wait_results_in();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_items(250);

		wait_results_in();
		repeat (SETTLE_CYC) @(negedge clk);
		if (fail_count == 0) begin
			$display("sorted_rate_table_floor_lookup_test passed");
		end else begin
			$display("sorted_rate_table_floor_lookup_test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("sorted_rate_table_floor_lookup_test failed");
		$finish;
	end

endmodule
